// ===== hdl/positional_list_store_unit_defines.svh =====
// Assertion macros used by the list store datapath.
// The module that uses them must have clk and rst_n in scope.
`ifndef POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pls_pkg.sv =====
package pls_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic load;
        logic rd_pos;
        logic rd_idx;
        logic wr_pos_val;
        logic wr_ins;
        logic wr_rem;
        logic idx_init_ins;
        logic idx_init_rem;
        logic idx_inc;
        logic idx_dec;
        logic cnt_inc;
        logic cnt_dec;
        logic result_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic bad;
        logic ins_tail;
        logic rem_tail;
        logic idx_at_pos;
        logic idx_at_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== hdl/positional_list_store_unit.sv =====
// Channel   Direction  Payload
// s_*       in         command, position, value
// m_*       out        read_value, bad_position, entry_count, is_empty
//
// A write, a rejected request, or an insert or remove at the end of the list is handled in the
// decode state and then loads its result; a read passes a wait state first. The next request
// is taken in the cycle after the result is loaded. A shifting insert reads and writes each
// moved entry and then puts the value in, a shifting remove reads and writes each moved entry.
// The result stalls while the output register is full and not taken; reset empties the list
// at once without clearing the entries, and a new request is taken while a result waits.

module positional_list_store_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // command [1:0], position [8:2], value [40:9], zero [47:41]
    input  logic [pls_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // read_value [31:0], bad_position [32], entry_count [39:33], is_empty [40], zero [47:41]
    output logic [pls_pkg::OUT_W-1:0] m_tdata
);

    pls_pkg::ctrl_cmd_t cmd;
    pls_pkg::ctrl_sts_t sts;

    pls_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pls_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== hdl/pls_ctrl.sv =====
module pls_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pls_pkg::ctrl_sts_t sts,
    output pls_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_WAIT,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_PUT,
        ST_REM_RD,
        ST_REM_WR,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.bad)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    unique case (sts.cmd)
                        pls_pkg::CMD_READ:
                        begin
                            cmd.rd_pos = 1'b1;
                            state_next = ST_RD_WAIT;
                        end
                        pls_pkg::CMD_WRITE:
                        begin
                            cmd.wr_pos_val = 1'b1;
                            state_next     = ST_FINISH;
                        end
                        pls_pkg::CMD_INSERT:
                        begin
                            if (sts.ins_tail)
                            begin
                                cmd.wr_pos_val = 1'b1;
                                cmd.cnt_inc    = 1'b1;
                                state_next     = ST_FINISH;
                            end
                            else
                            begin
                                cmd.idx_init_ins = 1'b1;
                                state_next       = ST_INS_RD;
                            end
                        end
                        pls_pkg::CMD_REMOVE:
                        begin
                            if (sts.rem_tail)
                            begin
                                cmd.cnt_dec = 1'b1;
                                state_next  = ST_FINISH;
                            end
                            else
                            begin
                                cmd.idx_init_rem = 1'b1;
                                state_next       = ST_REM_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_INS_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = ST_INS_WR;
            end
            ST_INS_WR:
            begin
                cmd.wr_ins = 1'b1;
                if (sts.idx_at_pos)
                begin
                    state_next = ST_INS_PUT;
                end
                else
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = ST_INS_RD;
                end
            end
            ST_INS_PUT:
            begin
                cmd.wr_pos_val = 1'b1;
                cmd.cnt_inc    = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_REM_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = ST_REM_WR;
            end
            ST_REM_WR:
            begin
                cmd.wr_rem = 1'b1;
                if (sts.idx_at_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_REM_RD;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/pls_datapath.sv =====
`include "positional_list_store_unit_defines.svh"

module pls_datapath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pls_pkg::IN_W-1:0]   in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [pls_pkg::OUT_W-1:0]  out_data,
    input  pls_pkg::ctrl_cmd_t         cmd,
    output pls_pkg::ctrl_sts_t         sts
);

    localparam int ADDR_W  = pls_pkg::ADDR_W;
    localparam int COUNT_W = pls_pkg::COUNT_W;
    localparam int CMP_W   = pls_pkg::CMP_W;
    localparam int POS_W   = pls_pkg::POS_W;
    localparam int DATA_W  = pls_pkg::DATA_W;
    localparam int CMD_W   = pls_pkg::CMD_W;
    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(pls_pkg::CAPACITY);

    logic [DATA_W-1:0]  mem [pls_pkg::CAPACITY];

    pls_pkg::cmd_t      cmd_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [DATA_W-1:0]  val_reg;
    logic               bad_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [DATA_W-1:0]  rdata_reg;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_value_reg;
    logic               out_bad_reg;
    logic [POS_W-1:0]   out_count_reg;
    logic               out_empty_reg;

    pls_pkg::cmd_t      in_cmd;
    logic [CMP_W-1:0]   in_pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   pos_ext;
    logic               in_bad;
    logic [ADDR_W-1:0]  pos_addr;
    logic [ADDR_W-1:0]  last_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic               mem_we;
    logic               load_non_read;

    assign in_cmd     = pls_pkg::cmd_t'(in_data[CMD_W-1:0]);
    assign in_pos_ext = CMP_W'(in_data[CMD_W +: POS_W]);
    assign cnt_ext    = CMP_W'(count_reg);
    assign pos_ext    = CMP_W'(pos_reg);
    assign pos_addr   = pos_ext[ADDR_W-1:0];
    assign last_addr  = ADDR_W'(count_reg - COUNT_W'(1));

    always_comb
    begin
        if (in_cmd == pls_pkg::CMD_INSERT)
        begin
            in_bad = (in_pos_ext > cnt_ext) || (cnt_ext == CMP_W'(pls_pkg::CAPACITY));
        end
        else
        begin
            in_bad = (in_pos_ext >= cnt_ext);
        end
    end

    always_comb
    begin
        rd_addr = cmd.rd_pos ? pos_addr : idx_reg;
        mem_we  = cmd.wr_pos_val | cmd.wr_ins | cmd.wr_rem;
        wr_data = cmd.wr_pos_val ? val_reg : rdata_reg;
        priority if (cmd.wr_pos_val)
        begin
            wr_addr = pos_addr;
        end
        else if (cmd.wr_ins)
        begin
            wr_addr = idx_reg + ADDR_W'(1);
        end
        else
        begin
            wr_addr = idx_reg - ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_pos || cmd.rd_idx)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_cmd;
            pos_reg <= in_data[CMD_W +: POS_W];
            val_reg <= in_data[CMD_W + POS_W +: DATA_W];
            bad_reg <= in_bad;
        end
        priority if (cmd.idx_init_ins)
        begin
            idx_reg <= last_addr;
        end
        else if (cmd.idx_init_rem)
        begin
            idx_reg <= pos_addr + ADDR_W'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + ADDR_W'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_reg <= idx_reg - ADDR_W'(1);
        end
        if (cmd.result_load)
        begin
            out_value_reg <= (cmd_reg == pls_pkg::CMD_READ && !bad_reg) ? rdata_reg : '0;
            out_bad_reg   <= bad_reg;
            out_count_reg <= cnt_ext[POS_W-1:0];
            out_empty_reg <= (count_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.cmd         = cmd_reg;
        sts.bad         = bad_reg;
        sts.ins_tail    = (pos_ext == cnt_ext);
        sts.rem_tail    = ((pos_ext + CMP_W'(1)) == cnt_ext);
        sts.idx_at_pos  = (idx_reg == pos_addr);
        sts.idx_at_last = (idx_reg == last_addr);
        sts.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {7'd0, out_empty_reg, out_count_reg, out_bad_reg, out_value_reg};

    assign load_non_read = cmd.result_load && (cmd_reg != pls_pkg::CMD_READ);

    `PLS_ASSERT_SAME(a_count_range, 1'b1, count_reg <= CAP_COUNT, "Entry count exceeds capacity.")
    `PLS_ASSERT_SAME(a_no_write_when_bad, mem_we, !bad_reg, "Rejected request modified the list.")
    `PLS_ASSERT_SAME(a_inc_not_full, cmd.cnt_inc, count_reg < CAP_COUNT, "Insert on a full list.")
    `PLS_ASSERT_NEXT(a_value_zero, load_non_read, out_value_reg == '0, "Non-read value not zero.")

endmodule

// ===== dv/tb.sv =====
module tb;

    typedef struct {
        pls_pkg::cmd_t              command;
        logic [pls_pkg::POS_W-1:0]  position;
        logic [pls_pkg::DATA_W-1:0] value;
        int unsigned                gap;
        bit                         drain_first;
    } list_request_t;

    typedef struct {
        logic [pls_pkg::DATA_W-1:0] read_value;
        logic                       bad_position;
        logic [pls_pkg::POS_W-1:0]  entry_count;
        logic                       is_empty;
    } list_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    // command [1:0], position [8:2], value [40:9], zero [47:41]
    logic [pls_pkg::IN_W-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    // read_value [31:0], bad_position [32], entry_count [39:33], is_empty [40], zero [47:41]
    logic [pls_pkg::OUT_W-1:0] m_tdata;

    list_request_t              pending_requests[$];
    list_result_t               expected_results[$];
    logic [pls_pkg::DATA_W-1:0] list_model [pls_pkg::CAPACITY];
    int                         list_len = 0;
    int                         gen_len = 0;
    int                         send_calm = 0;
    int                         recv_calm = 0;
    int                         recv_wait = 0;
    int                         send_wait = 0;
    bit                         staged = 1'b0;
    list_request_t              staged_req;
    list_request_t              active_req;
    int                         requests_sent = 0;
    int                         results_seen = 0;
    int                         sent_now;
    int                         error_count = 0;
    int                         commands_seen [4] = '{0, 0, 0, 0};
    int                         rejected = 0;
    int                         full_rejects = 0;
    list_result_t               observed;
    list_result_t               oldest;

    positional_list_store_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic apply_list_command(input list_request_t req);
        list_result_t res;
        int           pos;
        pos = int'(req.position);
        res.read_value = '0;
        res.bad_position = 1'b0;
        case (req.command)
            pls_pkg::CMD_READ:
            begin
                if (pos >= list_len)
                    res.bad_position = 1'b1;
                else
                    res.read_value = list_model[pos];
            end
            pls_pkg::CMD_WRITE:
            begin
                if (pos >= list_len)
                    res.bad_position = 1'b1;
                else
                    list_model[pos] = req.value;
            end
            pls_pkg::CMD_INSERT:
            begin
                if (pos > list_len || list_len >= pls_pkg::CAPACITY)
                begin
                    res.bad_position = 1'b1;
                    if (list_len >= pls_pkg::CAPACITY)
                        full_rejects++;
                end
                else
                begin
                    for (int i = list_len; i > pos; i--)
                        list_model[i] = list_model[i-1];
                    list_model[pos] = req.value;
                    list_len++;
                end
            end
            default:
            begin
                if (pos >= list_len)
                    res.bad_position = 1'b1;
                else
                begin
                    for (int i = pos; i < list_len - 1; i++)
                        list_model[i] = list_model[i+1];
                    list_len--;
                end
            end
        endcase
        res.entry_count = list_len[pls_pkg::POS_W-1:0];
        res.is_empty = (list_len == 0);
        commands_seen[int'(req.command)]++;
        if (res.bad_position)
            rejected++;
        expected_results.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [pls_pkg::DATA_W-1:0] exp_val,
                               input logic [pls_pkg::DATA_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val,
                     act_val);
        end
    endtask

    task automatic add_request(input pls_pkg::cmd_t command, input int pos,
                               input logic [pls_pkg::DATA_W-1:0] value,
                               input bit drain_first);
        list_request_t req;
        req.command = command;
        req.position = pos[pls_pkg::POS_W-1:0];
        req.value = value;
        req.drain_first = drain_first;
        if (send_calm > 0)
        begin
            send_calm--;
            req.gap = 0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            send_calm = $urandom_range(20, 60);
            req.gap = 0;
        end
        else
            req.gap = $urandom_range(0, 6);
        if (command == pls_pkg::CMD_INSERT && pos <= gen_len && gen_len < pls_pkg::CAPACITY)
            gen_len++;
        else if (command == pls_pkg::CMD_REMOVE && pos < gen_len)
            gen_len--;
        pending_requests.push_back(req);
    endtask

    function automatic logic [pls_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_valid_request(input pls_pkg::cmd_t command, input bit drain_first);
        pls_pkg::cmd_t chosen;
        int            pos;
        chosen = command;
        if (chosen != pls_pkg::CMD_INSERT && gen_len == 0)
            chosen = pls_pkg::CMD_INSERT;
        if (chosen == pls_pkg::CMD_INSERT && gen_len >= pls_pkg::CAPACITY)
            chosen = pls_pkg::CMD_REMOVE;
        if (chosen == pls_pkg::CMD_INSERT)
            pos = $urandom_range(0, gen_len);
        else
            pos = $urandom_range(0, gen_len - 1);
        add_request(chosen, pos, random_value(), drain_first);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            staged = 1'b0;
            send_wait = 0;
        end
        else
        begin
            sent_now = requests_sent;
            if (s_tvalid && s_tready)
            begin
                apply_list_command(active_req);
                sent_now = requests_sent + 1;
                requests_sent <= sent_now;
            end
            if (!s_tvalid || s_tready)
            begin
                if (!staged && pending_requests.size() > 0)
                begin
                    staged_req = pending_requests.pop_front();
                    staged = 1'b1;
                    send_wait = staged_req.gap;
                end
                if (!staged)
                    s_tvalid <= 1'b0;
                else if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (staged_req.drain_first && sent_now != results_seen)
                    s_tvalid <= 1'b0;
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(pls_pkg::IN_W-41){1'b0}}, staged_req.value,
                                staged_req.position, staged_req.command};
                    active_req = staged_req;
                    staged = 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                observed.read_value = m_tdata[31:0];
                observed.bad_position = m_tdata[32];
                observed.entry_count = m_tdata[39:33];
                observed.is_empty = m_tdata[40];
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             m_tdata);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("read_value", oldest.read_value, observed.read_value);
                    check_field("bad_position", 32'(oldest.bad_position),
                                32'(observed.bad_position));
                    check_field("entry_count", 32'(oldest.entry_count),
                                32'(observed.entry_count));
                    check_field("is_empty", 32'(oldest.is_empty), 32'(observed.is_empty));
                end
                if (recv_calm > 0)
                begin
                    recv_calm--;
                    recv_wait = 0;
                end
                else if ($urandom_range(0, 39) == 0)
                begin
                    recv_calm = $urandom_range(20, 60);
                    recv_wait = 0;
                end
                else
                    recv_wait = $urandom_range(0, 6);
            end
            if ((m_tvalid && m_tready) || !m_tready)
            begin
                if (recv_wait > 0)
                begin
                    recv_wait--;
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #2000000;
        $display("positional_list_store_unit regression: fail");
        $finish;
    end

    initial
    begin
        int  phase_len;
        int  roll;
        bit  first_phase;
        bit  drain_flag;

        // Commands on an empty list, then a short list built and taken apart.
        add_request(pls_pkg::CMD_READ, 0, 32'h1234_5678, 1'b0);
        add_request(pls_pkg::CMD_WRITE, 0, 32'hdead_beef, 1'b0);
        add_request(pls_pkg::CMD_REMOVE, 0, 32'h0, 1'b0);
        add_request(pls_pkg::CMD_INSERT, 1, 32'h1111_1111, 1'b0);
        add_request(pls_pkg::CMD_READ, 64, 32'h0, 1'b0);
        add_request(pls_pkg::CMD_INSERT, 0, 32'h7fff_ffff, 1'b0);
        add_request(pls_pkg::CMD_INSERT, 0, 32'h8000_0000, 1'b0);
        add_request(pls_pkg::CMD_INSERT, 2, 32'h0000_0000, 1'b0);
        add_request(pls_pkg::CMD_INSERT, 1, 32'hffff_ffff, 1'b0);
        add_request(pls_pkg::CMD_INSERT, 5, 32'h2222_2222, 1'b0);
        for (int i = 0; i < 4; i++)
            add_request(pls_pkg::CMD_READ, i, 32'hffff_ffff, 1'b0);
        add_request(pls_pkg::CMD_WRITE, 3, 32'haaaa_aaaa, 1'b0);
        add_request(pls_pkg::CMD_WRITE, 0, 32'h5555_5555, 1'b0);
        add_request(pls_pkg::CMD_WRITE, 4, 32'h3333_3333, 1'b0);
        add_request(pls_pkg::CMD_READ, 3, 32'h0, 1'b0);
        add_request(pls_pkg::CMD_REMOVE, 0, 32'h0, 1'b0);
        add_request(pls_pkg::CMD_REMOVE, 2, 32'h0, 1'b0);
        add_request(pls_pkg::CMD_REMOVE, 64, 32'h0, 1'b0);
        add_request(pls_pkg::CMD_READ, 0, 32'h0, 1'b0);
        add_request(pls_pkg::CMD_READ, 1, 32'h0, 1'b0);
        add_request(pls_pkg::CMD_REMOVE, 0, 32'h0, 1'b0);
        add_request(pls_pkg::CMD_REMOVE, 0, 32'h0, 1'b0);

        first_phase = 1'b1;
        while (pending_requests.size() < 1410)
        begin
            drain_flag = first_phase || ($urandom_range(0, 2) == 0);
            roll = first_phase ? 0 : $urandom_range(0, 2);
            first_phase = 1'b0;
            if (roll == 0)
            begin
                while (gen_len < pls_pkg::CAPACITY)
                begin
                    add_valid_request(($urandom_range(0, 4) == 0) ?
                                      pls_pkg::CMD_READ : pls_pkg::CMD_INSERT,
                                      drain_flag);
                    drain_flag = 1'b0;
                end
                phase_len = $urandom_range(1, 3);
                for (int i = 0; i < phase_len; i++)
                    add_request(pls_pkg::CMD_INSERT, $urandom_range(0, 64), random_value(),
                                1'b0);
            end
            else if (roll == 1)
            begin
                while (gen_len > 0)
                begin
                    add_valid_request(($urandom_range(0, 4) == 0) ?
                                      pls_pkg::cmd_t'($urandom_range(0, 1)) :
                                      pls_pkg::CMD_REMOVE,
                                      drain_flag);
                    drain_flag = 1'b0;
                end
                phase_len = $urandom_range(1, 3);
                for (int i = 0; i < phase_len; i++)
                    add_request(pls_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 64),
                                random_value(), 1'b0);
            end
            else
            begin
                phase_len = $urandom_range(30, 80);
                for (int i = 0; i < phase_len; i++)
                begin
                    if ($urandom_range(0, 99) < 15)
                        add_request(pls_pkg::cmd_t'($urandom_range(0, 3)),
                                    $urandom_range(0, 64), random_value(), drain_flag);
                    else
                        add_valid_request(pls_pkg::cmd_t'($urandom_range(0, 3)), drain_flag);
                    drain_flag = 1'b0;
                end
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || staged || s_tvalid ||
               results_seen != requests_sent)
            @(posedge clk);
        repeat (2 * pls_pkg::CAPACITY + 10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("%0t: results missing, expected %0d more, actual 0", $time,
                     expected_results.size());
        end

        $display("Covered %0d requests: %0d reads, %0d writes, %0d inserts, %0d removes.",
                 requests_sent, commands_seen[0], commands_seen[1], commands_seen[2],
                 commands_seen[3]);
        $display("Of these %0d were rejected, %0d of them inserts into a full list.",
                 rejected, full_rejects);
        if (error_count == 0)
            $display("positional_list_store_unit regression: pass");
        else
            $display("positional_list_store_unit regression: fail");
        $finish;
    end

endmodule
